@@ rtl/clex_pkg.sv @@
// Shared constants, token codes, keyword table and character classes for the lexer.
package clex_pkg;

    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = 2;
    localparam int CNT_W     = 3;

    localparam int POSITION_BITS_DEF     = 16;
    localparam int KEYWORD_MAX_CHARS_DEF = 6;

    typedef logic [4:0]  kind_t;
    typedef logic [1:0]  err_t;
    typedef logic [7:0]  char_t;
    typedef logic [15:0] field16_t;

    localparam kind_t K_EOF    = 5'd0;
    localparam kind_t K_INTLIT = 5'd7;
    localparam kind_t K_STRLIT = 5'd8;
    localparam kind_t K_ID     = 5'd9;
    localparam kind_t K_PLUS   = 5'd10;
    localparam kind_t K_MINUS  = 5'd11;
    localparam kind_t K_STAR   = 5'd12;
    localparam kind_t K_SLASH  = 5'd13;
    localparam kind_t K_ASSIGN = 5'd14;
    localparam kind_t K_ANDAND = 5'd15;
    localparam kind_t K_OROR   = 5'd16;
    localparam kind_t K_NOT    = 5'd17;
    localparam kind_t K_EQ     = 5'd18;
    localparam kind_t K_NE     = 5'd19;
    localparam kind_t K_LT     = 5'd20;
    localparam kind_t K_GT     = 5'd21;
    localparam kind_t K_LE     = 5'd22;
    localparam kind_t K_GE     = 5'd23;
    localparam kind_t K_COMMA  = 5'd24;
    localparam kind_t K_SEMI   = 5'd25;
    localparam kind_t K_LPAREN = 5'd26;
    localparam kind_t K_RPAREN = 5'd27;
    localparam kind_t K_LBRACE = 5'd28;
    localparam kind_t K_RBRACE = 5'd29;

    localparam err_t ERR_NONE    = 2'd0;
    localparam err_t ERR_UNKNOWN = 2'd1;
    localparam err_t ERR_UNTERM  = 2'd2;

    localparam char_t CH_END    = 8'h00;
    localparam char_t CH_NL     = 8'h0A;
    localparam char_t CH_QUOTE  = 8'h22;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_AMP    = 8'h26;
    localparam char_t CH_PIPE   = 8'h7C;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_EQUAL  = 8'h3D;
    localparam char_t CH_BANG   = 8'h21;
    localparam char_t CH_LESS   = 8'h3C;
    localparam char_t CH_GREAT  = 8'h3E;
    localparam char_t CH_UNDER  = 8'h5F;

    localparam int KW_COUNT = 6;
    // Keyword text packed first byte highest, as the buffer shifts in.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0069_6E74,   // int
        64'h0000_0000_766F_6964,   // void
        64'h0000_0000_0000_6966,   // if
        64'h0000_0000_656C_7365,   // else
        64'h0000_0077_6869_6C65,   // while
        64'h0000_7265_7475_726E    // return
    };
    localparam field16_t KW_LEN [KW_COUNT] = '{
        16'd3, 16'd4, 16'd2, 16'd4, 16'd5, 16'd6
    };
    localparam kind_t KW_KIND [KW_COUNT] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6
    };

    function automatic logic is_digit(input char_t c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input char_t c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input char_t c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_op_lead(input char_t c);
        return (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_LESS) || (c == CH_GREAT)
            || (c == CH_AMP) || (c == CH_PIPE) || (c == CH_SLASH);
    endfunction

    // Single-byte token kind, K_EOF where the byte is no punctuation.
    function automatic kind_t single_kind(input char_t c);
        kind_t k;
        unique case (c)
            8'h2B:    k = K_PLUS;
            8'h2D:    k = K_MINUS;
            8'h2A:    k = K_STAR;
            CH_SLASH: k = K_SLASH;
            CH_EQUAL: k = K_ASSIGN;
            CH_BANG:  k = K_NOT;
            CH_LESS:  k = K_LT;
            CH_GREAT: k = K_GT;
            8'h2C:    k = K_COMMA;
            8'h3B:    k = K_SEMI;
            8'h28:    k = K_LPAREN;
            8'h29:    k = K_RPAREN;
            8'h7B:    k = K_LBRACE;
            8'h7D:    k = K_RBRACE;
            default:  k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic field16_t sat_inc16(input field16_t v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    typedef struct packed {
        kind_t    kind;
        err_t     err;
        field16_t line;
        field16_t col;
        field16_t start;
        field16_t length;
        logic     last;
    } res_t;

endpackage

@@ rtl/c_subset_lexer.sv @@
// Streaming lexer for a small C subset: one source byte in, token beats out.
// A result beat is written into the result queue when the byte that causes it is taken.
// Accepts one byte per cycle while in_ready is high; a byte that yields two results
// is absorbed by a four-entry result queue (in_ready drops below two free).
// Reset (rst_n low, asynchronous): idle, line and column 1, offset 0, queue empty.
// The end byte (0) flushes, emits EOF and returns the scanner to its reset state.
module c_subset_lexer #(
    parameter int POSITION_BITS     = clex_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = clex_pkg::KEYWORD_MAX_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [1:0]  error_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_col,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    localparam int KwBits = 8 * KEYWORD_MAX_CHARS;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_ESCAPE,
        M_OPER,
        M_COMMENT,
        M_DISCARD
    } mode_t;

    typedef logic [POSITION_BITS-1:0] pos_t;

    // Scanner state
    mode_t                       mode_reg,  mode_next;
    pos_t                        pos_reg,   pos_next;
    clex_pkg::field16_t          line_reg,  line_next;
    clex_pkg::field16_t          col_reg,   col_next;
    pos_t                        ppos_reg,  ppos_next;
    clex_pkg::field16_t          pline_reg, pline_next;
    clex_pkg::field16_t          pcol_reg,  pcol_next;
    clex_pkg::field16_t          len_reg,   len_next;
    logic [KwBits-1:0]           kw_reg,    kw_next;
    clex_pkg::char_t             pop_reg,   pop_next;

    // Result queue
    clex_pkg::res_t              fifo_reg [clex_pkg::RES_DEPTH];
    logic [clex_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [clex_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [clex_pkg::CNT_W-1:0]  count_reg,  count_next;

    logic                        take;
    logic                        give;
    clex_pkg::char_t             c;

    // Flushed pending result and the byte's own result
    logic                        fv, sv, fresh;
    clex_pkg::res_t              f, s;
    clex_pkg::res_t              slot0, slot1;
    logic                        push0, push1;
    clex_pkg::kind_t             id_kind;
    clex_pkg::field16_t          len_inc;

    function automatic clex_pkg::field16_t sat_pos(input pos_t p);
        logic [31:0] w;
        w = 32'(p);
        return (w > 32'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    assign c        = char_code;
    assign in_ready = (count_reg <= clex_pkg::CNT_W'(clex_pkg::RES_DEPTH - 2));
    assign take     = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign give     = out_valid && out_ready;
    assign len_inc  = clex_pkg::sat_inc16(len_reg);

    assign token_kind   = fifo_reg[rd_ptr_reg].kind;
    assign error_kind   = fifo_reg[rd_ptr_reg].err;
    assign token_line   = fifo_reg[rd_ptr_reg].line;
    assign token_col    = fifo_reg[rd_ptr_reg].col;
    assign token_start  = fifo_reg[rd_ptr_reg].start;
    assign token_length = fifo_reg[rd_ptr_reg].length;
    assign last_of_run  = fifo_reg[rd_ptr_reg].last;

    // Keyword match: parallel compare of the short buffer against each keyword.
    always_comb
    begin
        id_kind = clex_pkg::K_ID;
        if (len_reg <= 16'(KEYWORD_MAX_CHARS))
        begin
            for (int i = 0; i < clex_pkg::KW_COUNT; i++)
            begin
                if ((len_reg == clex_pkg::KW_LEN[i])
                    && (kw_reg == KwBits'(clex_pkg::KW_TEXT[i])))
                begin
                    id_kind = clex_pkg::KW_KIND[i];
                end
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        ppos_next  = ppos_reg;
        pline_next = pline_reg;
        pcol_next  = pcol_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        pop_next   = pop_reg;
        fv    = 1'b0;
        sv    = 1'b0;
        fresh = 1'b0;

        f        = '0;
        f.line   = pline_reg;
        f.col    = pcol_reg;
        f.start  = sat_pos(ppos_reg);
        f.err    = clex_pkg::ERR_NONE;
        s        = '0;
        s.line   = line_reg;
        s.col    = col_reg;
        s.start  = sat_pos(pos_reg);
        s.err    = clex_pkg::ERR_NONE;

        // Finish or extend whatever is pending
        unique case (mode_reg)
            M_IDENT:
            begin
                if (clex_pkg::is_alpha(c) || clex_pkg::is_digit(c))
                begin
                    if (len_reg < 16'(KEYWORD_MAX_CHARS))
                        kw_next = {kw_reg[KwBits-9:0], c};
                    len_next = len_inc;
                end
                else
                begin
                    fv        = 1'b1;
                    f.kind    = id_kind;
                    f.length  = len_reg;
                    mode_next = M_IDLE;
                    fresh     = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (clex_pkg::is_digit(c))
                    len_next = len_inc;
                else
                begin
                    fv        = 1'b1;
                    f.kind    = clex_pkg::K_INTLIT;
                    f.length  = len_reg;
                    mode_next = M_IDLE;
                    fresh     = 1'b1;
                end
            end
            M_STRING, M_ESCAPE:
            begin
                if (c == clex_pkg::CH_END)
                begin
                    fv        = 1'b1;
                    f.kind    = clex_pkg::K_EOF;
                    f.err     = clex_pkg::ERR_UNTERM;
                    mode_next = M_IDLE;
                    fresh     = 1'b1;
                end
                else
                begin
                    len_next = len_inc;
                    if (mode_reg == M_ESCAPE)
                        mode_next = M_STRING;
                    else if (c == clex_pkg::CH_BSLASH)
                        mode_next = M_ESCAPE;
                    else if (c == clex_pkg::CH_QUOTE)
                    begin
                        fv        = 1'b1;
                        f.kind    = clex_pkg::K_STRLIT;
                        f.length  = len_inc;
                        mode_next = M_IDLE;
                    end
                end
            end
            M_OPER:
            begin
                mode_next = M_IDLE;
                if ((pop_reg == clex_pkg::CH_SLASH) && (c == clex_pkg::CH_SLASH))
                    mode_next = M_COMMENT;
                else if ((pop_reg == clex_pkg::CH_AMP) || (pop_reg == clex_pkg::CH_PIPE))
                begin
                    fv = 1'b1;
                    if (c == pop_reg)
                    begin
                        f.kind   = (pop_reg == clex_pkg::CH_AMP) ? clex_pkg::K_ANDAND
                                                                 : clex_pkg::K_OROR;
                        f.length = 16'd2;
                    end
                    else
                    begin
                        // Lone & or |: report it and drop the rest of the source
                        f.kind = clex_pkg::K_EOF;
                        f.err  = clex_pkg::ERR_UNKNOWN;
                        if (c != clex_pkg::CH_END)
                            mode_next = M_DISCARD;
                        else
                            fresh = 1'b1;
                    end
                end
                else if ((c == clex_pkg::CH_EQUAL) && (pop_reg != clex_pkg::CH_SLASH))
                begin
                    fv       = 1'b1;
                    f.length = 16'd2;
                    priority if (pop_reg == clex_pkg::CH_EQUAL)
                        f.kind = clex_pkg::K_EQ;
                    else if (pop_reg == clex_pkg::CH_BANG)
                        f.kind = clex_pkg::K_NE;
                    else if (pop_reg == clex_pkg::CH_LESS)
                        f.kind = clex_pkg::K_LE;
                    else
                        f.kind = clex_pkg::K_GE;
                end
                else
                begin
                    fv       = 1'b1;
                    f.kind   = clex_pkg::single_kind(pop_reg);
                    f.length = 16'd1;
                    fresh    = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if ((c == clex_pkg::CH_END) || (c == clex_pkg::CH_NL))
                begin
                    mode_next = M_IDLE;
                    fresh     = 1'b1;
                end
            end
            M_DISCARD:
            begin
                if (c == clex_pkg::CH_END)
                begin
                    mode_next = M_IDLE;
                    fresh     = 1'b1;
                end
            end
            M_IDLE:
            begin
                fresh = 1'b1;
            end
            default:
            begin
                mode_next = M_IDLE;
                fresh     = 1'b1;
            end
        endcase

        // Treat the byte on its own
        if (fresh)
        begin
            priority if (c == clex_pkg::CH_END)
            begin
                sv = 1'b1;
                s.kind = clex_pkg::K_EOF;
            end
            else if (clex_pkg::is_space(c))
            begin
                mode_next = mode_next;
            end
            else if (clex_pkg::is_digit(c) || clex_pkg::is_alpha(c)
                     || (c == clex_pkg::CH_QUOTE) || clex_pkg::is_op_lead(c))
            begin
                ppos_next  = pos_reg;
                pline_next = line_reg;
                pcol_next  = col_reg;
                len_next   = 16'd1;
                priority if (clex_pkg::is_digit(c))
                    mode_next = M_NUMBER;
                else if (clex_pkg::is_alpha(c))
                begin
                    mode_next = M_IDENT;
                    kw_next   = KwBits'(c);
                end
                else if (c == clex_pkg::CH_QUOTE)
                    mode_next = M_STRING;
                else
                begin
                    mode_next = M_OPER;
                    pop_next  = c;
                end
            end
            else if (clex_pkg::single_kind(c) != clex_pkg::K_EOF)
            begin
                sv       = 1'b1;
                s.kind   = clex_pkg::single_kind(c);
                s.length = 16'd1;
            end
            else
            begin
                sv        = 1'b1;
                s.kind    = clex_pkg::K_EOF;
                s.err     = clex_pkg::ERR_UNKNOWN;
                mode_next = M_DISCARD;
            end
        end

        // Advance position counters, or return to reset state after the end byte
        if (fresh && (c == clex_pkg::CH_END))
        begin
            mode_next  = M_IDLE;
            pos_next   = '0;
            line_next  = 16'd1;
            col_next   = 16'd1;
            ppos_next  = '0;
            pline_next = 16'd1;
            pcol_next  = 16'd1;
            len_next   = '0;
            kw_next    = '0;
            pop_next   = '0;
        end
        else
        begin
            if (c == clex_pkg::CH_NL)
            begin
                line_next = clex_pkg::sat_inc16(line_reg);
                col_next  = 16'd1;
            end
            else
                col_next = clex_pkg::sat_inc16(col_reg);
            pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
        end

        // Pack results into queue slots, marking the last one of the run
        slot0 = fv ? f : s;
        slot1 = s;
        push0 = take && (fv || sv);
        push1 = take && fv && sv;
        if (fv && sv)
            slot1.last = 1'b1;
        else
            slot0.last = 1'b1;

        wr_ptr_next = wr_ptr_reg + clex_pkg::PTR_W'(push0) + clex_pkg::PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + clex_pkg::PTR_W'(give);
        count_next  = count_reg + clex_pkg::CNT_W'(push0) + clex_pkg::CNT_W'(push1)
                      - clex_pkg::CNT_W'(give);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd1;
            ppos_reg   <= '0;
            pline_reg  <= 16'd1;
            pcol_reg   <= 16'd1;
            len_reg    <= '0;
            kw_reg     <= '0;
            pop_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                ppos_reg  <= ppos_next;
                pline_reg <= pline_next;
                pcol_reg  <= pcol_next;
                len_reg   <= len_next;
                kw_reg    <= kw_next;
                pop_reg   <= pop_next;
            end
            if (push0)
                fifo_reg[wr_ptr_reg] <= slot0;
            if (push1)
                fifo_reg[clex_pkg::PTR_W'(wr_ptr_reg + 1'b1)] <= slot1;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= clex_pkg::CNT_W'(clex_pkg::RES_DEPTH))
        else $error("result queue overflow");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (c == clex_pkg::CH_END))
        |=> ((pos_reg == '0) && (line_reg == 16'd1) && (col_reg == 16'd1)
             && (mode_reg == M_IDLE)))
        else $error("end byte did not return scanner to reset state");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (token_kind == clex_pkg::K_EOF) && (error_kind == clex_pkg::ERR_NONE))
        |-> last_of_run)
        else $error("EOF beat not last of its run");

    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_kind != clex_pkg::ERR_NONE)) |-> (token_length == 16'd0))
        else $error("error beat with nonzero length");

    a_str_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == M_STRING) || (mode_reg == M_ESCAPE)) |-> (len_reg != 16'd0))
        else $error("open string with zero length");

endmodule
